[design/lvdl_pkg.sv]
// Package for the vibrato delay line: shared types, fixed-point constants
// and the sine magnitude lookup. No dependencies.
`default_nettype none

package lvdl_pkg;

   // Widths fixed by the sample formats
   localparam int SAMPLE_W    = 12;
   localparam int RING_WORD_W = 13;
   localparam int DEPTH_W     = 16;
   localparam int FRAC_W      = 16;
   localparam int STEP_W      = 17;

   localparam logic [RING_WORD_W-1:0] MIDSCALE  = 13'd2048;
   localparam logic [SAMPLE_W-1:0]    DAC_MAX   = 12'd4095;
   localparam logic [31:0]            LFO_STEP_RESET = 32'd486958;

   // Depth = knob * 0.8 * 65536 / 4095, done as multiply then reciprocal
   localparam logic [15:0] DEPTH_SCALE = 16'd52429;
   localparam int          KNOB_SHIFT  = 40;
   localparam logic [63:0] KNOB_RECIP  = ((64'd1 << 40) + 64'd4094) / 64'd4095;

   // Excursion divide by 127 through a reciprocal
   localparam int          EXC_SHIFT  = 31;
   localparam logic [63:0] EXC_RECIP  = ((64'd1 << 31) + 64'd126) / 64'd127;
   localparam logic [6:0]  EXC_ROUND  = 7'd126;

   // Sine index scaling shift
   localparam int ROM_SHIFT = 34;

   localparam logic [STEP_W-1:0] UNIT_STEP = 17'd65536;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEPTH_MUL,
      ST_ROM_MUL,
      ST_SINE,
      ST_EXC_MUL,
      ST_EXC_DIV,
      ST_PTR,
      ST_RD_I0,
      ST_RD_I1,
      ST_CAP_B1,
      ST_INTERP,
      ST_OUT
   } state_type;

   // Per-state strobes from the sequencer
   typedef struct packed {
      logic accept;
      logic depth_mul;
      logic rom_mul;
      logic sine_rd;
      logic exc_mul;
      logic exc_div;
      logic ptr_upd;
      logic rd_i0;
      logic rd_i1;
      logic cap_b1;
      logic interp_mul;
      logic out_load;
   } ctrl_type;

   // First quadrant of trunc(127 * sin), 65 points
   localparam logic [6:0] QUARTER_SINE [0:64] = '{
      7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,  7'd24,  7'd27,
      7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,  7'd48,  7'd51,  7'd54,  7'd57,
      7'd59,  7'd62,  7'd65,  7'd67,  7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,
      7'd85,  7'd87,  7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
      7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116, 7'd117, 7'd118,
      7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123, 7'd124, 7'd125, 7'd125, 7'd126,
      7'd126, 7'd126, 7'd126, 7'd126, 7'd127
   };

   // Magnitude of the sine entry; the sign is idx[7]
   function automatic logic [6:0] sine_mag(input logic [7:0] idx);
      logic [6:0] q;
      logic [7:0] mirror;
      q      = idx[6:0];
      mirror = 8'd128 - {1'b0, q};
      if (q <= 7'd64) begin
         sine_mag = QUARTER_SINE[q];
      end else begin
         sine_mag = QUARTER_SINE[mirror[6:0]];
      end
   endfunction

endpackage

`default_nettype wire

[design/lfo_vibrato_delay_line.sv]
// Vibrato delay line top level: CSR, ring addressing, ring RAM, output
// register. Uses lvdl_pkg, lvdl_ram, lvdl_ctrl, lvdl_lfo, lvdl_interp.
//
// Usage:
//   req_*  : one audio sample and one knob reading per transaction;
//            accepted when req_valid is high and req_stall low.
//   rsp_*  : exactly one interpolated output sample per accepted input,
//            in order, taken when rsp_valid is high and rsp_stall low.
//   csr_*  : write of the LFO phase step; csr_ready is always high.
// Sequencing: an item is accepted in the idle state and its result
// reaches the output register in the output step; no further input is
// taken until the sequencer returns to idle. The pace is set by the
// item sequencer, which walks each sample through the modulation multiply
// and reciprocal steps and two reads of the single ring read port.
// The output register lets the next item in while a result is waiting;
// if rsp_stall holds that result, the following item waits in its last
// step and req_stall stays high until the output register frees.
// Reset (synchronous) returns the pointer, phase, depth and counters to
// zero and the step to its default; the ring reads as zero until each
// slot is written, tracked by a fill count, so no clearing pass is needed.
`default_nettype none

module lfo_vibrato_delay_line
   import lvdl_pkg::*;
#(
   parameter int RING_DEPTH   = 512,
   parameter int SINE_ENTRIES = 256,
   parameter int KNOB_PERIOD  = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_audio_sample,
   input  wire logic [SAMPLE_W-1:0] req_depth_knob,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [SAMPLE_W-1:0] rsp_dac_value,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [31:0]         csr_lfo_step
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PW = AW + FRAC_W;

   ctrl_type               ctrl;
   logic [31:0]            lfo_step_ff;
   logic [AW-1:0]          write_slot_ff;
   logic [AW:0]            fill_ff;
   logic                   hit_ff;
   logic                   rsp_valid_ff;
   logic [SAMPLE_W-1:0]    rsp_dac_value_ff;

   logic                   out_free;
   logic [PW-1:0]          read_pos;
   logic [AW-1:0]          i0;
   logic [AW-1:0]          i1;
   logic                   ram_we;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr;
   logic [RING_WORD_W-1:0] ram_wdata;
   logic [RING_WORD_W-1:0] ram_rdata;
   logic [RING_WORD_W-1:0] ring_word;
   logic [SAMPLE_W-1:0]    dac_value;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // CSR register
   always_ff @(posedge clock) begin
      if (reset) begin
         lfo_step_ff <= LFO_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         lfo_step_ff <= csr_lfo_step;
      end
   end

   lvdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_stall (req_stall),
      .ctrl      (ctrl)
   );

   lvdl_lfo #(
      .RING_DEPTH   (RING_DEPTH),
      .SINE_ENTRIES (SINE_ENTRIES),
      .KNOB_PERIOD  (KNOB_PERIOD)
   ) u_lfo (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .lfo_step   (lfo_step_ff),
      .depth_knob (req_depth_knob),
      .read_pos   (read_pos)
   );

   // Ring addressing: write on accept, then read i0 and i1
   always_comb begin
      i0        = read_pos[PW-1:FRAC_W];
      i1        = (i0 == AW'(RING_DEPTH - 1)) ? '0 : i0 + 1'b1;
      ram_we    = ctrl.accept;
      ram_wdata = {1'b0, req_audio_sample} - MIDSCALE;
      ram_re    = ctrl.rd_i0 || ctrl.rd_i1;
      ram_raddr = ctrl.rd_i1 ? i1 : i0;
      ring_word = hit_ff ? ram_rdata : '0;
   end

   // Write slot and fill count; unwritten slots read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         fill_ff       <= '0;
      end else if (ctrl.accept) begin
         if (write_slot_ff == AW'(RING_DEPTH - 1)) begin
            write_slot_ff <= '0;
         end else begin
            write_slot_ff <= write_slot_ff + 1'b1;
         end
         if (fill_ff != (AW+1)'(RING_DEPTH)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   // Slot-written flag travels with the read data
   always_ff @(posedge clock) begin
      if (ram_re) begin
         hit_ff <= ({1'b0, ram_raddr} < fill_ff);
      end
   end

   lvdl_ram #(
      .WIDTH (RING_WORD_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (write_slot_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lvdl_interp u_interp (
      .clock     (clock),
      .ctrl      (ctrl),
      .ring_word (ring_word),
      .frac      (read_pos[FRAC_W-1:0]),
      .dac_value (dac_value)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_dac_value_ff <= dac_value;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dac_value = rsp_dac_value_ff;

`ifndef SYNTHESIS
   // Ring write and ring reads never share a cycle
   a_ring_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ring read and write in the same cycle");

   // Fill count never passes the ring depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= (AW+1)'(RING_DEPTH)))
      else $error("fill count beyond ring depth");
`endif

endmodule

`default_nettype wire

[design/lvdl_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lvdl_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/lvdl_ctrl.sv]
// Item sequencer for the vibrato delay line: walks one item through the
// modulation, ring read and interpolation steps. Uses lvdl_pkg.
`default_nettype none

module lvdl_ctrl
   import lvdl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic out_free,
   output logic      req_stall,
   output ctrl_type  ctrl
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DEPTH_MUL;
         ST_DEPTH_MUL: state_in = ST_ROM_MUL;
         ST_ROM_MUL:   state_in = ST_SINE;
         ST_SINE:      state_in = ST_EXC_MUL;
         ST_EXC_MUL:   state_in = ST_EXC_DIV;
         ST_EXC_DIV:   state_in = ST_PTR;
         ST_PTR:       state_in = ST_RD_I0;
         ST_RD_I0:     state_in = ST_RD_I1;
         ST_RD_I1:     state_in = ST_CAP_B1;
         ST_CAP_B1:    state_in = ST_INTERP;
         ST_INTERP:    state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Strobes
   always_comb begin
      ctrl      = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:      ctrl.accept     = req_valid;
         ST_DEPTH_MUL: ctrl.depth_mul  = 1'b1;
         ST_ROM_MUL:   ctrl.rom_mul    = 1'b1;
         ST_SINE:      ctrl.sine_rd    = 1'b1;
         ST_EXC_MUL:   ctrl.exc_mul    = 1'b1;
         ST_EXC_DIV:   ctrl.exc_div    = 1'b1;
         ST_PTR:       ctrl.ptr_upd    = 1'b1;
         ST_RD_I0:     ctrl.rd_i0      = 1'b1;
         ST_RD_I1:     ctrl.rd_i1      = 1'b1;
         ST_CAP_B1:    ctrl.cap_b1     = 1'b1;
         ST_INTERP:    ctrl.interp_mul = 1'b1;
         ST_OUT:       ctrl.out_load   = out_free;
         default:      ctrl            = '0;
      endcase
   end

`ifndef SYNTHESIS
   // An accepted transaction always starts the modulation chain
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      ctrl.accept |=> (state_ff == ST_DEPTH_MUL))
      else $error("accepted transaction did not start the sequence");

   // A blocked result holds the sequencer in the output step
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !out_free) |=> (state_ff == ST_OUT))
      else $error("sequencer left output step with result blocked");
`endif

endmodule

`default_nettype wire

[design/lvdl_lfo.sv]
// Modulation path: knob depth, LFO phase, sine lookup, excursion and the
// fixed-point read pointer. Uses lvdl_pkg.
`default_nettype none

module lvdl_lfo
   import lvdl_pkg::*;
#(
   parameter int RING_DEPTH   = 512,
   parameter int SINE_ENTRIES = 256,
   parameter int KNOB_PERIOD  = 256
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ctrl_type                             ctrl,
   input  wire logic [31:0]                          lfo_step,
   input  wire logic [SAMPLE_W-1:0]                  depth_knob,
   output logic      [$clog2(RING_DEPTH)+FRAC_W-1:0] read_pos
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PW = AW + FRAC_W;
   localparam int TW = (KNOB_PERIOD > 1) ? $clog2(KNOB_PERIOD) : 1;
   localparam int JW = $clog2(SINE_ENTRIES);
   localparam int SW = $clog2(SINE_ENTRIES + 1);
   localparam logic [63:0] ROM_RECIP =
      ((64'd1 << ROM_SHIFT) + 64'(SINE_ENTRIES) - 64'd1) / 64'(SINE_ENTRIES);
   localparam logic [PW:0] POS_MOD = (PW+1)'(RING_DEPTH) << FRAC_W;

   logic [TW-1:0]        knob_tick_ff;
   logic [SAMPLE_W-1:0]  knob_ff;
   logic                 knob_load_ff;
   logic [31:0]          phase_ff;
   logic [27:0]          knob_prod_ff;
   logic [JW-1:0]        j_ff;
   logic [DEPTH_W-1:0]   mod_depth_ff;
   logic [7:0]           rom_idx_ff;
   logic [6:0]           s_mag_ff;
   logic                 s_neg_ff;
   logic [22:0]          exc_ff;
   logic                 exc_neg_ff;
   logic [DEPTH_W-1:0]   q_ff;
   logic [PW-1:0]        read_pos_ff;

   logic [32+SW-1:0]     j_prod;
   logic [56:0]          depth_prod;
   logic [JW+8+30:0]     rom_prod;
   logic [47:0]          q_prod;
   logic [22:0]          exc_in;
   logic [STEP_W-1:0]    step_in;
   logic [PW:0]          pos_sum;
   logic [PW:0]          pos_wrap;

   // Products and pointer arithmetic
   always_comb begin
      j_prod     = (32+SW)'(phase_ff) * (32+SW)'(SINE_ENTRIES);
      depth_prod = 57'(knob_prod_ff) * 57'(KNOB_RECIP[28:0]);
      rom_prod   = (JW+39)'({j_ff, 8'd0}) * (JW+39)'(ROM_RECIP[30:0]);
      exc_in     = 23'(s_mag_ff) * 23'(mod_depth_ff);
      if (s_neg_ff) begin
         exc_in = exc_in + 23'(EXC_ROUND);
      end
      q_prod     = 48'(exc_ff) * 48'(EXC_RECIP[24:0]);
      if (exc_neg_ff) begin
         step_in = UNIT_STEP - STEP_W'(q_ff);
      end else begin
         step_in = UNIT_STEP + STEP_W'(q_ff);
      end
      pos_sum  = (PW+1)'(read_pos_ff) + (PW+1)'(step_in);
      pos_wrap = (pos_sum >= POS_MOD) ? (pos_sum - POS_MOD) : pos_sum;
   end

   // Architectural state: tick, phase, depth, pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         knob_tick_ff <= '0;
         phase_ff     <= '0;
         mod_depth_ff <= '0;
         read_pos_ff  <= '0;
      end else begin
         if (ctrl.accept) begin
            phase_ff <= phase_ff + lfo_step;
            if (knob_tick_ff == TW'(KNOB_PERIOD - 1)) begin
               knob_tick_ff <= '0;
            end else begin
               knob_tick_ff <= knob_tick_ff + 1'b1;
            end
         end
         if (ctrl.rom_mul && knob_load_ff) begin
            mod_depth_ff <= depth_prod[KNOB_SHIFT +: DEPTH_W];
         end
         if (ctrl.ptr_upd) begin
            read_pos_ff <= pos_wrap[PW-1:0];
         end
      end
   end

   // Per-item pipeline registers
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         knob_ff      <= depth_knob;
         knob_load_ff <= (knob_tick_ff == TW'(KNOB_PERIOD - 1));
      end
      if (ctrl.depth_mul) begin
         knob_prod_ff <= 28'(knob_ff) * 28'(DEPTH_SCALE);
         j_ff         <= j_prod[32 +: JW];
      end
      if (ctrl.rom_mul) begin
         rom_idx_ff <= rom_prod[ROM_SHIFT +: 8];
      end
      if (ctrl.sine_rd) begin
         s_mag_ff <= sine_mag(rom_idx_ff);
         s_neg_ff <= rom_idx_ff[7];
      end
      if (ctrl.exc_mul) begin
         exc_ff     <= exc_in;
         exc_neg_ff <= s_neg_ff;
      end
      if (ctrl.exc_div) begin
         q_ff <= q_prod[EXC_SHIFT +: DEPTH_W];
      end
   end

   assign read_pos = read_pos_ff;

`ifndef SYNTHESIS
   // Pointer stays inside the ring
   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, read_pos_ff} < POS_MOD))
      else $error("read pointer outside the ring");
`endif

endmodule

`default_nettype wire

[design/lvdl_interp.sv]
// Linear interpolation between two ring words, recentering and clamping.
// Uses lvdl_pkg.
`default_nettype none

module lvdl_interp
   import lvdl_pkg::*;
(
   input  wire logic                     clock,
   input  wire ctrl_type                 ctrl,
   input  wire logic [RING_WORD_W-1:0]   ring_word,
   input  wire logic [FRAC_W-1:0]        frac,
   output logic      [SAMPLE_W-1:0]      dac_value
);

   logic signed [RING_WORD_W-1:0] b0_ff;
   logic signed [RING_WORD_W-1:0] b1_ff;
   logic signed [30:0]            prod_ff;

   logic signed [RING_WORD_W:0]   diff;
   logic signed [30:0]            prod_in;
   logic signed [15:0]            sum;

   // Difference times fraction
   always_comb begin
      diff    = $signed({b1_ff[RING_WORD_W-1], b1_ff}) -
                $signed({b0_ff[RING_WORD_W-1], b0_ff});
      prod_in = 31'(diff) * 31'($signed({1'b0, frac}));
   end

   // Capture ring words and the product
   always_ff @(posedge clock) begin
      if (ctrl.rd_i1) begin
         b0_ff <= $signed(ring_word);
      end
      if (ctrl.cap_b1) begin
         b1_ff <= $signed(ring_word);
      end
      if (ctrl.interp_mul) begin
         prod_ff <= prod_in;
      end
   end

   // Floor shift, recenter, clamp
   always_comb begin
      sum = 16'(b0_ff) + 16'($signed(prod_ff[30:16])) + $signed(16'(MIDSCALE));
      if (sum < 16'sd0) begin
         dac_value = '0;
      end else if (sum > $signed(16'(DAC_MAX))) begin
         dac_value = DAC_MAX;
      end else begin
         dac_value = sum[SAMPLE_W-1:0];
      end
   end

endmodule

`default_nettype wire

[tb/lfo_vibrato_delay_line_test.sv]
// Self-checking testbench for the vibrato delay line: a scoreboard class
// predicts every output sample from the accepted inputs and LFO step.
// Depends on lvdl_pkg and the lfo_vibrato_delay_line design files.
`timescale 1ns / 100ps

module lfo_vibrato_delay_line_test
   import lvdl_pkg::*;
();

   localparam int RING_SLOTS   = 512;
   localparam int KNOB_EVERY   = 256;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 162;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   // First quadrant of trunc(127 * sin(2*pi*i/256))
   localparam int SINE_QTR [0:64] = '{
      0, 3, 6, 9, 12, 15, 18, 21, 24, 27,
      30, 33, 36, 39, 42, 45, 48, 51, 54, 57,
      59, 62, 65, 67, 70, 73, 75, 78, 80, 82,
      85, 87, 89, 91, 94, 96, 98, 100, 102, 103,
      105, 107, 108, 110, 112, 113, 114, 116, 117, 118,
      119, 120, 121, 122, 123, 123, 124, 125, 125, 126,
      126, 126, 126, 126, 127
   };

   // Directed transactions: {audio_sample, depth_knob}
   localparam logic [23:0] DIRECTED [0:19] = '{
      {12'd0,    12'd0},    {12'd4095, 12'd4095}, {12'd2048, 12'd0},
      {12'd2047, 12'd4095}, {12'd1,    12'd1},    {12'd4094, 12'd4094},
      {12'hAAA,  12'h555},  {12'h555,  12'hAAA},  {12'd0,    12'd4095},
      {12'd4095, 12'd0},    {12'd0,    12'd0},    {12'd4095, 12'd4095},
      {12'd0,    12'd2048}, {12'd4095, 12'd2047}, {12'h800,  12'h7FF},
      {12'h7FF,  12'h800},  {12'd4095, 12'd0},    {12'd0,    12'd4095},
      {12'hF0F,  12'h0F0},  {12'h0F0,  12'hF0F}
   };

   // Predicts the output stream of the delay line
   class vibrato_scoreboard;
      logic signed [12:0] ring_mem [RING_SLOTS];
      logic [8:0]  wr_slot;
      logic [24:0] rd_pos;
      logic [31:0] lfo_acc;
      logic [31:0] lfo_inc;
      logic [7:0]  knob_count;
      logic [15:0] depth_q16;
      logic [SAMPLE_W-1:0] dac_expected [$];
      int errors;

      function new();
         foreach (ring_mem[k]) ring_mem[k] = '0;
         wr_slot    = '0;
         rd_pos     = '0;
         lfo_acc    = '0;
         lfo_inc    = 32'd486958;
         knob_count = '0;
         depth_q16  = '0;
         errors     = 0;
      endfunction

      function void set_lfo_step(input logic [31:0] value);
         lfo_inc = value;
      endfunction

      function int pending();
         return dac_expected.size();
      endfunction

      // One accepted input transaction advances the model by one sample
      function void note_input(input logic [SAMPLE_W-1:0] smp,
                               input logic [SAMPLE_W-1:0] knob);
         int q;
         int sine_val;
         longint prod;
         longint excursion;
         longint b0;
         longint b1;
         longint frac;
         longint mix;
         logic [24:0] pos;
         logic [8:0] i0;
         logic [8:0] i1;

         // knob is sampled once per period
         knob_count = knob_count + 8'd1;
         if (knob_count == 8'd0) begin
            depth_q16 = 16'((longint'(knob) * 52429) / 4095);
         end

         ring_mem[wr_slot] = $signed({1'b0, smp}) - 13'sd2048;
         wr_slot = wr_slot + 9'd1;

         // LFO sine lookup, sign from the top index bit
         lfo_acc = lfo_acc + lfo_inc;
         q = int'(lfo_acc[30:24]);
         sine_val = (q <= 64) ? SINE_QTR[q] : SINE_QTR[128 - q];
         if (lfo_acc[31]) begin
            sine_val = -sine_val;
         end

         // floor division of the excursion by 127
         prod = longint'(sine_val) * longint'(depth_q16);
         if (prod >= 0) begin
            excursion = prod / 127;
         end else begin
            excursion = -((-prod + 126) / 127);
         end
         pos = 25'(longint'(rd_pos) + 65536 + excursion);
         rd_pos = pos;

         // linear interpolation between neighbors, floor via shift
         i0   = pos[24:16];
         i1   = i0 + 9'd1;
         frac = longint'(pos[15:0]);
         b0   = ring_mem[i0];
         b1   = ring_mem[i1];
         mix  = b0 + (((b1 - b0) * frac) >>> 16) + 2048;
         if (mix < 0) mix = 0;
         if (mix > 4095) mix = 4095;
         dac_expected.push_back(SAMPLE_W'(mix));
      endfunction

      task report_mismatch(input string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(input logic [SAMPLE_W-1:0] got);
         logic [SAMPLE_W-1:0] want;
         if (dac_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected dac_value %0d", got));
         end else begin
            want = dac_expected.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("dac_value %0d, expected %0d", got, want));
            end
         end
      endtask
   endclass

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_audio_sample = '0;
   logic [SAMPLE_W-1:0] req_depth_knob   = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [SAMPLE_W-1:0] rsp_dac_value;
   logic                csr_valid        = 1'b0;
   logic                csr_ready;
   logic [31:0]         csr_lfo_step     = '0;

   logic rsp_quiet   = 1'b0;
   logic long_hold   = 1'b0;
   bit   send_quiet  = 1'b0;
   int   item_count  = 0;
   int   cycle_count = 0;
   event hold_go;

   vibrato_scoreboard sb = new();

   lfo_vibrato_delay_line i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_audio_sample (req_audio_sample),
      .req_depth_knob   (req_depth_knob),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_value    (rsp_dac_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_lfo_step     (csr_lfo_step)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Output side: check each transaction, then draw the next stall
   initial begin
      int wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_dac_value);
            wait_left = rsp_quiet ? 0 : $urandom_range(7);
         end
         if (long_hold) begin
            rsp_stall <= 1'b1;
         end else if (wait_left > 0) begin
            rsp_stall <= 1'b1;
            wait_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Long output hold-off so the block backs up into its input
   initial begin
      forever begin
         @(hold_go);
         long_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   // Offer one input transaction; valid stays high when the next follows at once
   task automatic send_item(input logic [SAMPLE_W-1:0] smp,
                            input logic [SAMPLE_W-1:0] knob);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_audio_sample <= smp;
      req_depth_knob   <= knob;
      do @(posedge clock); while (req_stall);
      sb.note_input(smp, knob);
      item_count++;
   endtask

   // Random samples; the knob on each depth update cycles max, random, zero
   task automatic run_items(input int count);
      logic [SAMPLE_W-1:0] smp;
      logic [SAMPLE_W-1:0] knob;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(7))
            0:       smp = '0;
            1:       smp = '1;
            default: smp = SAMPLE_W'($urandom_range(4095));
         endcase
         knob = SAMPLE_W'($urandom);
         if (item_count % KNOB_EVERY == KNOB_EVERY - 1) begin
            case ((item_count / KNOB_EVERY) % 3)
               0:       knob = '1;
               1:       knob = SAMPLE_W'($urandom);
               default: knob = '0;
            endcase
         end
         send_item(smp, knob);
      end
   endtask

   // Register write, only with the block drained
   task automatic write_lfo_step(input logic [31:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid    <= 1'b1;
      csr_lfo_step <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_lfo_step(value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            1: write_lfo_step(32'hFFFF_FFFF);
            2: write_lfo_step(32'h0000_0000);
            3: write_lfo_step(32'h0100_0000);
            4: write_lfo_step($urandom);
            5: write_lfo_step(32'h4000_0000);
            6: write_lfo_step(32'h02AB_CDEF);
            default: ;
         endcase
         send_quiet = (ph % 3 == 1);
         rsp_quiet <= (ph % 3 == 2);
         if (ph == 0) begin
            foreach (DIRECTED[k]) send_item(DIRECTED[k][23:12], DIRECTED[k][11:0]);
         end
         if (ph == 3) begin
            -> hold_go;
         end
         run_items(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
design/lvdl_pkg.sv
design/lvdl_ram.sv
design/lvdl_ctrl.sv
design/lvdl_lfo.sv
design/lvdl_interp.sv
design/lfo_vibrato_delay_line.sv
tb/lfo_vibrato_delay_line_test.sv
